// ===== sv/pcrc_pkg.sv =====
package pcrc_pkg;

    localparam int DIV_W  = 24;
    localparam int RATE_W = 32;
    localparam int IDX_W  = 8;
    localparam int CFG_W  = 36;

    localparam logic [RATE_W-1:0] XTAL_HZ = 32'd50000000;

    localparam logic [IDX_W-1:0] REG_SYS_STATUS   = 8'd0;
    localparam logic [IDX_W-1:0] REG_SYS_POWER    = 8'd1;
    localparam logic [IDX_W-1:0] REG_SYS_FEEDBACK = 8'd2;
    localparam logic [IDX_W-1:0] REG_SYS_POSTDIV  = 8'd3;
    localparam logic [IDX_W-1:0] REG_AUX_STATUS   = 8'd4;
    localparam logic [IDX_W-1:0] REG_AUX_POWER    = 8'd5;
    localparam logic [IDX_W-1:0] REG_AUX_FEEDBACK = 8'd6;
    localparam logic [IDX_W-1:0] REG_AUX_POSTDIV  = 8'd7;

    localparam logic [4:0] GSRC_SYS_HALF = 5'd0;
    localparam logic [4:0] GSRC_AUX      = 5'd1;
    localparam logic [4:0] GSRC_XTAL     = 5'd2;
    localparam logic [1:0] USRC_XTAL     = 2'd0;
    localparam logic [1:0] USRC_SYS      = 2'd2;

    typedef enum logic [1:0] {
        CALC_IDLE,
        CALC_MUL,
        CALC_DIV
    } calc_state_t;

    // one item in flight through the divider row
    typedef struct packed {
        logic              valid;
        logic [DIV_W-1:0]  rem;
        logic [RATE_W-1:0] num;
        logic [RATE_W-1:0] quot;
        logic [DIV_W-1:0]  dv;
    } div_lane_t;

endpackage

// ===== sv/pcrc_pll_calc.sv =====
module pcrc_pll_calc
    import pcrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       status,
    input  logic [31:0]       power,
    input  logic [35:0]       feedback,
    input  logic [31:0]       postdiv,
    output logic              busy,
    output logic [RATE_W-1:0] rate
);

    calc_state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [35:0] mult_reg, mult_next;
    logic [61:0] acc_reg, acc_next;
    logic [37:0] num_reg, num_next;
    logic [11:0] rem_reg, rem_next;
    logic [RATE_W-1:0] rate_reg, rate_next;

    logic [11:0] prod;
    logic        usable;
    logic [12:0] trial;

    assign prod   = 12'(status[5:0]) * 12'(postdiv[18:16]) * 12'(postdiv[14:12]);
    assign usable = status[31] && ((power[5:0] & 6'h29) == 6'd0) && (prod != 12'd0);
    assign trial  = {rem_reg, num_reg[37]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CALC_IDLE;
            rate_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rate_reg  <= rate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        mult_reg <= mult_next;
        acc_reg  <= acc_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mult_next  = mult_reg;
        acc_next   = acc_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        rate_next  = rate_reg;
        case (state_reg)
            CALC_MUL:
            begin
                // msb first shift-add of 50 MHz times feedback
                acc_next  = {acc_reg[60:0], 1'b0} +
                            (mult_reg[35] ? {30'd0, XTAL_HZ} : 62'd0);
                mult_next = {mult_reg[34:0], 1'b0};
                cnt_next  = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = CALC_DIV;
                    num_next   = acc_next[61:24];
                    rem_next   = '0;
                    cnt_next   = 6'd37;
                end
            end
            CALC_DIV:
            begin
                if (trial >= {1'b0, prod})
                begin
                    rem_next = 12'(trial - {1'b0, prod});
                    num_next = {num_reg[36:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[11:0];
                    num_next = {num_reg[36:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = CALC_IDLE;
                    rate_next  = (usable && num_next[37:32] == 6'd0) ? num_next[31:0] : '0;
                end
            end
            default:
            begin
            end
        endcase
        if (start)
        begin
            state_next = CALC_MUL;
            cnt_next   = 6'd35;
            acc_next   = '0;
            mult_next  = power[2] ? {feedback[35:24], 24'd0} : feedback;
        end
    end

    assign busy = (state_reg != CALC_IDLE);
    assign rate = rate_reg;

endmodule

// ===== sv/pcrc_div_cell.sv =====
module pcrc_div_cell
    import pcrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  div_lane_t lane_in,
    output div_lane_t lane_out
);

    logic      valid_reg;
    div_lane_t lane_reg, lane_next;
    logic [DIV_W:0] trial;

    assign trial = {lane_in.rem, lane_in.num[RATE_W-1]};

    always_comb
    begin
        lane_next     = lane_in;
        lane_next.num = {lane_in.num[RATE_W-2:0], 1'b0};
        if (trial >= {1'b0, lane_in.dv})
        begin
            lane_next.rem  = DIV_W'(trial - {1'b0, lane_in.dv});
            lane_next.quot = {lane_in.quot[RATE_W-2:0], 1'b1};
        end
        else
        begin
            lane_next.rem  = trial[DIV_W-1:0];
            lane_next.quot = {lane_in.quot[RATE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= lane_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            lane_reg <= lane_next;
    end

    always_comb
    begin
        lane_out       = lane_reg;
        lane_out.valid = valid_reg;
    end

endmodule

// ===== sv/pll_clock_rate_calculator_top.sv =====
// Each input transaction passes the row of 32 cells, one quotient bit per cell.
// Throughput: one transaction per cycle unless the output stalls or a recompute
// runs; the row advances as a whole. After any configuration write both PLL rates
// are recomputed bit-serially in parallel (the write is latched in a register, then
// 36 multiply plus 38 divide steps) and s_tready is low meanwhile.
// Reset: asynchronous, active low; configuration registers clear to zero, pipeline
// empties, PLL rates reset to zero.
module pll_clock_rate_calculator_top
    import pcrc_pkg::*;
#(
    parameter int ENABLE_BIT_POS = 11
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // clock_control[31:0], clock_divider[63:32]
    input  logic              s_tuser,   // gated_clock
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [RATE_W-1:0] m_tdata,   // rate_hz[31:0]
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int NCELL = RATE_W;

    logic [31:0] sys_status_reg, sys_power_reg, sys_postdiv_reg;
    logic [31:0] aux_status_reg, aux_power_reg, aux_postdiv_reg;
    logic [35:0] sys_fb_reg, aux_fb_reg;

    logic cfg_wr, cfg_wr_reg, sys_busy, aux_busy, adv;
    logic [RATE_W-1:0] sys_rate, aux_rate, parent;
    logic [31:0] ctl, dw;
    logic [DIV_W-1:0] dv;
    div_lane_t lanes [0:NCELL];

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_status_reg  <= '0;
            sys_power_reg   <= '0;
            sys_fb_reg      <= '0;
            sys_postdiv_reg <= '0;
            aux_status_reg  <= '0;
            aux_power_reg   <= '0;
            aux_fb_reg      <= '0;
            aux_postdiv_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_SYS_STATUS:   sys_status_reg  <= cfg_data[31:0];
                REG_SYS_POWER:    sys_power_reg   <= cfg_data[31:0];
                REG_SYS_FEEDBACK: sys_fb_reg      <= cfg_data;
                REG_SYS_POSTDIV:  sys_postdiv_reg <= cfg_data[31:0];
                REG_AUX_STATUS:   aux_status_reg  <= cfg_data[31:0];
                REG_AUX_POWER:    aux_power_reg   <= cfg_data[31:0];
                REG_AUX_FEEDBACK: aux_fb_reg      <= cfg_data;
                REG_AUX_POSTDIV:  aux_postdiv_reg <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencers start once the written value has landed in its register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_wr_reg <= 1'b0;
        else
            cfg_wr_reg <= cfg_wr;
    end

    pcrc_pll_calc u_sys_pll (
        .clk(clk), .rst_n(rst_n), .start(cfg_wr_reg),
        .status(sys_status_reg), .power(sys_power_reg),
        .feedback(sys_fb_reg), .postdiv(sys_postdiv_reg),
        .busy(sys_busy), .rate(sys_rate)
    );

    pcrc_pll_calc u_aux_pll (
        .clk(clk), .rst_n(rst_n), .start(cfg_wr_reg),
        .status(aux_status_reg), .power(aux_power_reg),
        .feedback(aux_fb_reg), .postdiv(aux_postdiv_reg),
        .busy(aux_busy), .rate(aux_rate)
    );

    assign ctl = s_tdata[31:0];
    assign dw  = s_tdata[63:32];

    always_comb
    begin
        parent = '0;
        if (s_tuser)
        begin
            dv = (dw[7:0] == 8'd0) ? DIV_W'(65536) : DIV_W'(dw[7:0]);
            if (ctl[ENABLE_BIT_POS])
            begin
                case (ctl[9:5])
                    GSRC_SYS_HALF: parent = sys_postdiv_reg[4] ? (sys_rate >> 1) : '0;
                    GSRC_AUX:      parent = aux_rate;
                    GSRC_XTAL:     parent = XTAL_HZ;
                    default:       parent = '0;
                endcase
            end
        end
        else
        begin
            dv = (dw[23:0] == 24'd0) ? DIV_W'(65536) : dw[23:0];
            case (ctl[1:0])
                USRC_XTAL: parent = XTAL_HZ;
                USRC_SYS:  parent = sys_rate;
                default:   parent = '0;
            endcase
        end
    end

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv && !cfg_wr_reg && !sys_busy && !aux_busy;

    always_comb
    begin
        lanes[0].valid = s_tvalid && s_tready;
        lanes[0].rem   = '0;
        lanes[0].num   = parent;
        lanes[0].quot  = '0;
        lanes[0].dv    = dv;
    end

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        pcrc_div_cell u_cell (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .lane_in(lanes[k]), .lane_out(lanes[k+1])
        );
    end

    assign m_tvalid = lanes[NCELL].valid;
    assign m_tdata  = lanes[NCELL].quot;

    // a write restarts the PLL sequencers, so no query may slip in right after
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !s_tready)
        else $error("query accepted during PLL recompute");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> lanes[1].valid)
        else $error("accepted transaction not in first cell");

    a_stall_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("accept while row stalled");

    a_stall_holds_row: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(lanes[1].valid))
        else $error("row moved while stalled");

endmodule
